>>> rtl/smdr_pkg.sv
// shared types for the signed multiply / divide / remainder unit
`timescale 1ns / 1ps
`default_nettype none

package smdr_pkg;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_REM = 2'd2
    } t_op;

    // per-transaction control that travels with the data down the cell chain
    typedef struct packed {
        logic is_mul;
        logic is_rem;
        logic zero;
        logic a_neg;
        logic q_neg;
    } t_tag;

endpackage

`default_nettype wire

>>> rtl/smdr_if.sv
// valid / ready channel interfaces for operands and results
`timescale 1ns / 1ps
`default_nettype none

interface smdr_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;

    modport source(output valid, output op, output operand_a, output operand_b, input ready);
    modport sink(input valid, input op, input operand_a, input operand_b, output ready);
endinterface

interface smdr_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result;

    modport source(output valid, output result, input ready);
    modport sink(input valid, input result, output ready);
endinterface

`default_nettype wire

>>> rtl/smdr_cell.sv
// one step cell: shift-add multiply bit or restoring divide bit
`timescale 1ns / 1ps
`default_nettype none

module smdr_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire smdr_pkg::t_tag        i_tag,
    input  wire logic [DATA_WIDTH-1:0] i_acc,
    input  wire logic [DATA_WIDTH-1:0] i_sh,
    input  wire logic [DATA_WIDTH-1:0] i_m,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output smdr_pkg::t_tag             o_tag,
    output logic [DATA_WIDTH-1:0]      o_acc,
    output logic [DATA_WIDTH-1:0]      o_sh,
    output logic [DATA_WIDTH-1:0]      o_m
);

    logic                  r_valid;
    smdr_pkg::t_tag        r_tag;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_sh;
    logic [DATA_WIDTH-1:0] r_m;

    logic [DATA_WIDTH-1:0] n_acc;
    logic [DATA_WIDTH-1:0] n_sh;
    logic [DATA_WIDTH-1:0] trial;
    logic                  fits;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // partial remainder stays below 2^(w-1), so the shifted value fits in w bits
        trial = {i_acc[DATA_WIDTH-2:0], i_sh[DATA_WIDTH-1]};
        fits  = trial >= i_m;
        if (i_tag.is_mul) begin
            n_acc = {i_acc[DATA_WIDTH-2:0], 1'b0} + (i_sh[DATA_WIDTH-1] ? i_m : '0);
            n_sh  = {i_sh[DATA_WIDTH-2:0], 1'b0};
        end else begin
            n_acc = fits ? (trial - i_m) : trial;
            n_sh  = {i_sh[DATA_WIDTH-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tag <= i_tag;
            r_acc <= n_acc;
            r_sh  <= n_sh;
            r_m   <= i_m;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_acc   = r_acc;
    assign o_sh    = r_sh;
    assign o_m     = r_m;

endmodule

`default_nettype wire

>>> rtl/signed_mul_div_rem_unit.sv
// top level: operand prep, chain of step cells, result register
`timescale 1ns / 1ps
`default_nettype none

// Signed multiply / divide / remainder unit. Takes op (0 multiply, 1 divide,
// 2 remainder) and two signed operands, returns one signed result. Multiply gives
// the low DATA_WIDTH bits of the product; divide truncates toward zero; remainder
// carries the sign of the dividend; a zero divisor or an unused op gives 0.
// One transaction is accepted every cycle unless back-pressure stalls the chain;
// each passes through the operand prep register, DATA_WIDTH step cells (one
// product or quotient bit per cell) and the result register. Each stage holds
// its item while the next one is not ready, so bubbles are squeezed out under
// back-pressure.
module signed_mul_div_rem_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    smdr_in_if.sink     i_in,
    smdr_out_if.source  o_out
);

    localparam int W = DATA_WIDTH;

    // operand prep stage
    logic           r_pv;
    smdr_pkg::t_tag r_ptag;
    logic [W-1:0]   r_pacc;
    logic [W-1:0]   r_psh;
    logic [W-1:0]   r_pm;

    smdr_pkg::t_tag n_ptag;
    logic [W-1:0]   n_pacc;
    logic [W-1:0]   n_psh;
    logic [W-1:0]   n_pm;
    logic [W-1:0]   a_u;
    logic [W-1:0]   b_u;
    logic [W-1:0]   mag_a;
    logic [W-1:0]   mag_b;
    logic           prep_ready;

    // cell chain
    logic           c_valid [W];
    logic           c_ready [W];
    smdr_pkg::t_tag c_tag   [W];
    logic [W-1:0]   c_acc   [W];
    logic [W-1:0]   c_sh    [W];
    logic [W-1:0]   c_m     [W];

    // result stage
    logic           r_ov;
    logic [W-1:0]   r_res;
    logic [W-1:0]   n_res;
    logic           out_ready;

    assign a_u   = i_in.operand_a;
    assign b_u   = i_in.operand_b;
    assign mag_a = a_u[W-1] ? ('0 - a_u) : a_u;
    assign mag_b = b_u[W-1] ? ('0 - b_u) : b_u;

    always_comb begin
        n_ptag       = '0;
        n_ptag.a_neg = a_u[W-1];
        n_ptag.q_neg = a_u[W-1] ^ b_u[W-1];
        n_pacc       = '0;
        n_psh        = mag_a;
        n_pm         = mag_b;
        unique case (smdr_pkg::t_op'(i_in.op))
            smdr_pkg::OP_MUL: begin
                n_ptag.is_mul = 1'b1;
                n_psh         = a_u;
                n_pm          = b_u;
            end
            smdr_pkg::OP_DIV: begin
                n_ptag.zero = (b_u == '0);
            end
            smdr_pkg::OP_REM: begin
                n_ptag.is_rem = 1'b1;
                n_ptag.zero   = (b_u == '0);
            end
            default: begin
                n_ptag.zero = 1'b1;
            end
        endcase
    end

    assign prep_ready = !r_pv || c_ready[0];
    assign i_in.ready = prep_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (prep_ready) begin
            r_pv <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prep_ready && i_in.valid) begin
            r_ptag <= n_ptag;
            r_pacc <= n_pacc;
            r_psh  <= n_psh;
            r_pm   <= n_pm;
        end
    end

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_cell
            if (k == 0) begin : g_first
                smdr_cell #(.DATA_WIDTH(W)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (r_pv),
                    .o_ready (c_ready[k]),
                    .i_tag   (r_ptag),
                    .i_acc   (r_pacc),
                    .i_sh    (r_psh),
                    .i_m     (r_pm),
                    .o_valid (c_valid[k]),
                    .i_ready ((k == W - 1) ? out_ready : c_ready[k+1]),
                    .o_tag   (c_tag[k]),
                    .o_acc   (c_acc[k]),
                    .o_sh    (c_sh[k]),
                    .o_m     (c_m[k])
                );
            end else if (k == W - 1) begin : g_last
                smdr_cell #(.DATA_WIDTH(W)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (c_valid[k-1]),
                    .o_ready (c_ready[k]),
                    .i_tag   (c_tag[k-1]),
                    .i_acc   (c_acc[k-1]),
                    .i_sh    (c_sh[k-1]),
                    .i_m     (c_m[k-1]),
                    .o_valid (c_valid[k]),
                    .i_ready (out_ready),
                    .o_tag   (c_tag[k]),
                    .o_acc   (c_acc[k]),
                    .o_sh    (c_sh[k]),
                    .o_m     (c_m[k])
                );
            end else begin : g_mid
                smdr_cell #(.DATA_WIDTH(W)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (c_valid[k-1]),
                    .o_ready (c_ready[k]),
                    .i_tag   (c_tag[k-1]),
                    .i_acc   (c_acc[k-1]),
                    .i_sh    (c_sh[k-1]),
                    .i_m     (c_m[k-1]),
                    .o_valid (c_valid[k]),
                    .i_ready (c_ready[k+1]),
                    .o_tag   (c_tag[k]),
                    .o_acc   (c_acc[k]),
                    .o_sh    (c_sh[k]),
                    .o_m     (c_m[k])
                );
            end
        end
    endgenerate

    // sign fix-up: quotient sits in the shift register, remainder in the accumulator
    always_comb begin
        if (c_tag[W-1].zero) begin
            n_res = '0;
        end else if (c_tag[W-1].is_mul) begin
            n_res = c_acc[W-1];
        end else if (c_tag[W-1].is_rem) begin
            n_res = c_tag[W-1].a_neg ? ('0 - c_acc[W-1]) : c_acc[W-1];
        end else begin
            n_res = c_tag[W-1].q_neg ? ('0 - c_sh[W-1]) : c_sh[W-1];
        end
    end

    assign out_ready = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_ready) begin
            r_ov <= c_valid[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && c_valid[W-1]) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid  = r_ov;
    assign o_out.result = r_res;

    // an accepted transaction always lands in the prep register
    a_prep_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_pv)
        else $error("accepted transaction missing from prep stage");

    // a finished item leaving the last cell always shows up as a result
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid[W-1] && out_ready |=> r_ov)
        else $error("finished item lost before result register");

    // a stalled result stage must hold back the last cell
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready && c_valid[W-1] |=> c_valid[W-1])
        else $error("last cell dropped an item under back-pressure");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// self-checking bench for the signed multiply / divide / remainder unit
`timescale 1ns / 1ps

module tb_top;

    localparam int DW = 32;
    localparam int LATENCY = DW + 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_IDLE = 13;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};

    logic i_clk;
    logic i_rst_n;

    smdr_in_if #(.DATA_WIDTH(DW)) in_if ();
    smdr_out_if #(.DATA_WIDTH(DW)) out_if ();

    signed_mul_div_rem_unit #(
        .DATA_WIDTH(DW)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [DW-1:0] pending_results[$];
    int            err_count = 0;
    int            idle_cycles = 0;
    bit            src_idle_en = 1'b1;
    bit            snk_idle_en = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // low DW bits of the product, or quotient / remainder on magnitudes with sign fixup
    function automatic logic [DW-1:0] arith_result(input logic [1:0] op,
                                                   input logic [DW-1:0] a,
                                                   input logic [DW-1:0] b);
        logic [DW-1:0] mag_a;
        logic [DW-1:0] mag_b;
        logic [DW-1:0] quo;
        logic [DW-1:0] rmd;
        logic [DW-1:0] res;
        mag_a = a[DW-1] ? -a : a;
        mag_b = b[DW-1] ? -b : b;
        quo = '0;
        rmd = '0;
        if (b != '0) begin
            quo = mag_a / mag_b;
            rmd = mag_a % mag_b;
        end
        case (op)
            smdr_pkg::OP_MUL: res = a * b;
            smdr_pkg::OP_DIV: res = (b == '0) ? '0 : ((a[DW-1] != b[DW-1]) ? -quo : quo);
            smdr_pkg::OP_REM: res = (b == '0) ? '0 : (a[DW-1] ? -rmd : rmd);
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 33) return smdr_pkg::OP_MUL;
        if (r < 66) return smdr_pkg::OP_DIV;
        if (r < 98) return smdr_pkg::OP_REM;
        return OP_UNUSED;
    endfunction

    function automatic logic [DW-1:0] rand_operand();
        logic [DW-1:0] v;
        int            s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4: begin
                s = int'($urandom_range(0, 32)) - 16;
                v = s;
            end
            5: begin
                case ($urandom_range(0, 4))
                    0: v = S_MIN;
                    1: v = S_MAX;
                    2: v = '1;
                    3: v = '0;
                    default: v = 1;
                endcase
            end
            6: begin
                v = 1 << $urandom_range(0, DW - 1);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            7: begin
                s = int'($urandom_range(0, 65535)) - 32768;
                v = s;
            end
            8: v = $urandom_range(0, 1) ? S_MIN + $urandom_range(0, 7)
                                         : S_MAX - $urandom_range(0, 7);
            default: v = '0;
        endcase
        return v;
    endfunction

    // one operand transaction; returns right after the accepting edge
    task automatic send_op(input logic [1:0] op, input logic [DW-1:0] a,
                           input logic [DW-1:0] b);
        int gap;
        gap = src_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.operand_a <= a;
        in_if.operand_b <= b;
        do @(posedge i_clk); while (!in_if.ready);
        pending_results.push_back(arith_result(op, a, b));
    endtask

    task automatic run_random(input int count);
        repeat (count) send_op(rand_op(), rand_operand(), rand_operand());
    endtask

    task automatic test_directed();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        // multiply wrap and sign combinations
        send_op(smdr_pkg::OP_MUL, S_MIN, S_MIN);
        send_op(smdr_pkg::OP_MUL, S_MAX, S_MAX);
        send_op(smdr_pkg::OP_MUL, S_MIN, -1);
        send_op(smdr_pkg::OP_MUL, -1, -1);
        send_op(smdr_pkg::OP_MUL, S_MAX, 2);
        // divide: truncation toward zero, most negative over minus one, zero divisor
        send_op(smdr_pkg::OP_DIV, 7, 2);
        send_op(smdr_pkg::OP_DIV, -7, 2);
        send_op(smdr_pkg::OP_DIV, 7, -2);
        send_op(smdr_pkg::OP_DIV, -7, -2);
        send_op(smdr_pkg::OP_DIV, S_MIN, -1);
        send_op(smdr_pkg::OP_DIV, S_MIN, 1);
        send_op(smdr_pkg::OP_DIV, S_MAX, S_MIN);
        send_op(smdr_pkg::OP_DIV, S_MIN, S_MIN);
        send_op(smdr_pkg::OP_DIV, 5, 0);
        // remainder follows the dividend sign
        send_op(smdr_pkg::OP_REM, 7, 2);
        send_op(smdr_pkg::OP_REM, -7, 2);
        send_op(smdr_pkg::OP_REM, 7, -2);
        send_op(smdr_pkg::OP_REM, -7, -2);
        send_op(smdr_pkg::OP_REM, S_MIN, -1);
        send_op(smdr_pkg::OP_REM, S_MIN, 3);
        send_op(smdr_pkg::OP_REM, -1, S_MIN);
        send_op(smdr_pkg::OP_REM, S_MIN, 0);
        send_op(smdr_pkg::OP_REM, 0, 0);
        // unused opcode gives zero
        send_op(OP_UNUSED, S_MAX, S_MAX);
        send_op(OP_UNUSED, S_MIN, -1);
    endtask

    task automatic test_random_with_gaps();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        run_random(550);
    endtask

    task automatic test_random_streaming();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        run_random(150);
    endtask

    task automatic test_random_backpressure();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b1;
        run_random(125);
    endtask

    task automatic test_random_slow_sender();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b0;
        run_random(125);
    endtask

    task automatic drain_and_report();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.op        <= smdr_pkg::OP_MUL;
        in_if.operand_a <= '0;
        in_if.operand_b <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_with_gaps();
        test_random_streaming();
        test_random_backpressure();
        test_random_slow_sender();
        drain_and_report();
    end

    // result side: random stall before each transaction while sink idling is enabled
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = snk_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    always @(posedge i_clk) begin
        logic [DW-1:0] want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result %h with nothing pending", out_if.result);
            end else begin
                want = pending_results.pop_front();
                if (out_if.result !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result mismatch: expected %h got %h", want, out_if.result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule

>>> signed_mul_div_rem_unit.f
rtl/smdr_pkg.sv
rtl/smdr_if.sv
rtl/smdr_cell.sv
rtl/signed_mul_div_rem_unit.sv
bench/tb_top.sv
